// ----- src/bmhq_pkg.sv -----
// Package for the binary min-heap queue: entry layout, status and command codes.
// Used by binary_min_heap_queue; depends on nothing else.
package bmhq_pkg;

  localparam int KEY_W   = 32;
  localparam int TAG_W   = 4;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;
  localparam int SLOTS_D = 16;

  // Commands carried by in_command
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One heap entry: signed key with its source list tag
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

endpackage

// ----- src/binary_min_heap_queue.sv -----
// Binary min-heap priority queue of (signed key, list tag) entries, held in one
// synchronous memory with a registered read port. Depends on bmhq_pkg.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_ready, in_command, in_value,    | to block
//           | in_list_tag                                  |
//   out     | out_valid, out_ready, out_status,            | from block
//           | out_min_value, out_min_tag, out_occupancy    |
//
// One word at a time. An insert climbs from the new last slot, reading each parent
// in turn; a remove reads the root, then the last entry, and descends, reading
// the children one after the other through the one read port.
// A refused word (full on insert, empty on remove) finishes sooner.
// Reset (rst_n low, synchronous) empties the heap; memory contents are left.
// A new word is taken while the last result still waits in the output register.
module binary_min_heap_queue #(
  parameter int SLOTS = bmhq_pkg::SLOTS_D
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [bmhq_pkg::KEY_W-1:0]   in_value,
  input  logic [bmhq_pkg::TAG_W-1:0]          in_list_tag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bmhq_pkg::STAT_W-1:0]         out_status,
  output logic signed [bmhq_pkg::KEY_W-1:0]   out_min_value,
  output logic [bmhq_pkg::TAG_W-1:0]          out_min_tag,
  output logic [bmhq_pkg::OCC_W-1:0]          out_occupancy
);

  import bmhq_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = IW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_UP, S_UP_CMP, S_RM_TOP, S_RM_LAST, S_DN, S_DN_L, S_DN_R
  } state_t;

  // Extra state value kept apart so DONE can be tested by name
  typedef enum logic {
    D_NO, D_YES
  } done_t;

  state_t          state_r, state_nxt;
  done_t           done_r, done_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  entry_t          cur_r, cur_nxt;
  entry_t          top_r, top_nxt;
  entry_t          best_r, best_nxt;
  logic            pick_r, pick_nxt;
  status_t         status_r, status_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  entry_t                   out_ent_r, out_ent_nxt;
  logic [OCC_W-1:0]         out_occ_r, out_occ_nxt;

  // Heap memory and its ports
  entry_t          heap_mem [SLOTS];
  entry_t          mem_rd_r;
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_wa, mem_ra;
  entry_t          mem_wd;

  // Index arithmetic for the current hole
  logic [XW-1:0]   left_x, right_x, count_x;
  logic [IW-1:0]   parent_idx, left_idx, right_idx;
  logic            in_acc;

  assign left_x     = XW'({pos_r, 1'b1});
  assign right_x    = left_x + XW'(1);
  assign count_x    = XW'(count_r);
  assign left_idx   = left_x[IW-1:0];
  assign right_idx  = right_x[IW-1:0];
  assign parent_idx = IW'((pos_r - IW'(1)) >> 1);
  assign in_acc     = in_valid && in_ready;

  assign in_ready      = (state_r == S_IDLE) && (done_r == D_NO);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_min_value = out_ent_r.key;
  assign out_min_tag   = out_ent_r.tag;
  assign out_occupancy = out_occ_r;

  // Sequence one insert or remove through the memory
  always_comb begin
    state_nxt      = state_r;
    done_nxt       = done_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    top_nxt        = top_r;
    best_nxt       = best_r;
    pick_nxt       = pick_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_occ_nxt    = out_occ_r;
    mem_we         = 1'b0;
    mem_wa         = pos_r;
    mem_wd         = cur_r;
    mem_re         = 1'b0;
    mem_ra         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          top_nxt    = '0;
          status_nxt = ST_OK;
          if (in_command == CMD_INSERT) begin
            if (count_r == CW'(SLOTS)) begin
              status_nxt = ST_FULL;
              done_nxt   = D_YES;
            end else begin
              cur_nxt.key = in_value;
              cur_nxt.tag = in_list_tag;
              pos_nxt     = count_r[IW-1:0];
              count_nxt   = count_r + CW'(1);
              state_nxt   = S_UP;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              done_nxt   = D_YES;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = '0;
              count_nxt = count_r - CW'(1);
              state_nxt = S_RM_TOP;
            end
          end
        end
      end
      // Climb: fetch the parent, or settle at the root
      S_UP: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_IDLE;
          done_nxt  = D_YES;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = parent_idx;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cur_r.key < mem_rd_r.key) begin
          mem_wd    = mem_rd_r;
          pos_nxt   = parent_idx;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_IDLE;
          done_nxt  = D_YES;
        end
      end
      // Capture the root, then fetch the last entry unless the heap is now empty
      S_RM_TOP: begin
        top_nxt = mem_rd_r;
        if (count_r == '0) begin
          state_nxt = S_IDLE;
          done_nxt  = D_YES;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = count_r[IW-1:0];
          state_nxt = S_RM_LAST;
        end
      end
      S_RM_LAST: begin
        cur_nxt   = mem_rd_r;
        pos_nxt   = '0;
        state_nxt = S_DN;
      end
      // Descend: fetch the left child, or settle at a leaf
      S_DN: begin
        if (left_x >= count_x) begin
          mem_we    = 1'b1;
          state_nxt = S_IDLE;
          done_nxt  = D_YES;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = left_idx;
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        pick_nxt = (mem_rd_r.key < cur_r.key);
        best_nxt = pick_nxt ? mem_rd_r : cur_r;
        if (right_x < count_x) begin
          mem_re    = 1'b1;
          mem_ra    = right_idx;
          state_nxt = S_DN_R;
        end else begin
          mem_we = 1'b1;
          if (pick_nxt) begin
            mem_wd    = mem_rd_r;
            pos_nxt   = left_idx;
            state_nxt = S_DN;
          end else begin
            state_nxt = S_IDLE;
            done_nxt  = D_YES;
          end
        end
      end
      S_DN_R: begin
        mem_we = 1'b1;
        if (mem_rd_r.key < best_r.key) begin
          mem_wd    = mem_rd_r;
          pos_nxt   = right_idx;
          state_nxt = S_DN;
        end else if (pick_r) begin
          mem_wd    = best_r;
          pos_nxt   = left_idx;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_IDLE;
          done_nxt  = D_YES;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hand the finished word to the output register once it is free
    if (done_r == D_YES && (!out_valid_r || out_ready)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_ent_nxt    = top_r;
      out_occ_nxt    = OCC_W'(count_r);
      done_nxt       = D_NO;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_r      <= D_NO;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    top_r        <= top_nxt;
    best_r       <= best_nxt;
    pick_r       <= pick_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // Heap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= heap_mem[mem_ra];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("entry count above capacity");

  a_no_rw_clash : assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("read and write of one entry in the same cycle");

  a_count_only_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(count_r))
    else $error("entry count moved without an accepted word");

  a_zero_min_unless_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_min_value == '0 && out_min_tag == '0))
    else $error("error result carries a nonzero entry");
`endif

endmodule
